[rtl/sgd_pkg.sv]
`timescale 1ns / 1ps

package sgd_pkg;

   // Width of the signed result and of the divisor register.
   localparam int VALUE_WIDTH   = 32;
   localparam int DIVISOR_WIDTH = 16;

   // The magnitude never exceeds 2^(VALUE_WIDTH-1)-1, so it needs one bit less.
   localparam int MAG_WIDTH = VALUE_WIDTH - 1;
   // Enough bits to hold a remainder width from 0 up to DIVISOR_WIDTH.
   localparam int BITS_WIDTH = $clog2(DIVISOR_WIDTH + 1);

   localparam logic [MAG_WIDTH-1:0] MAG_MAX = {MAG_WIDTH{1'b1}};

   typedef logic signed [VALUE_WIDTH-1:0] value_type;
   typedef logic [DIVISOR_WIDTH-1:0]      divisor_type;
   typedef logic [BITS_WIDTH-1:0]         bits_type;

   typedef enum logic [1:0] {
      PH_SIGN  = 2'd0,
      PH_UNARY = 2'd1,
      PH_REM   = 2'd2,
      PH_EXTRA = 2'd3
   } phase_type;

   // Remainder width b = ceil(log2 m), found as the bit length of m-1.
   function automatic bits_type code_width(input divisor_type m);
      divisor_type mm1;
      bits_type    w;
      mm1 = m - divisor_type'(1);
      w   = '0;
      for (int i = 0; i < DIVISOR_WIDTH; i++) begin
         if (mm1[i]) begin
            w = bits_type'(i + 1);
         end
      end
      return w;
   endfunction

   // Truncated binary threshold t = 2^b - m.
   function automatic divisor_type code_threshold(input divisor_type m, input bits_type b);
      logic [DIVISOR_WIDTH:0] pow;
      logic [DIVISOR_WIDTH:0] diff;
      pow  = (DIVISOR_WIDTH + 1)'(1) << b;
      diff = pow - {1'b0, m};
      return diff[DIVISOR_WIDTH-1:0];
   endfunction

endpackage

[rtl/sgd_if.sv]
`timescale 1ns / 1ps

// Request channel: one code bit per request.
interface sgd_req_if;
   logic valid;
   logic ready;
   logic code_bit;

   modport source (output valid, output code_bit, input ready);
   modport sink (input valid, input code_bit, output ready);
endinterface

// Response channel: one decoded value per completed codeword.
interface sgd_rsp_if;
   import sgd_pkg::*;
   logic      valid;
   logic      ready;
   value_type decoded_value;
   logic      overflow;

   modport source (output valid, output decoded_value, output overflow, input ready);
   modport sink (input valid, input decoded_value, input overflow, output ready);
endinterface

[rtl/signed_golomb_decoder.sv]
`timescale 1ns / 1ps

// Sign-magnitude Golomb decoder. Each request carries one bit of the coded
// stream; a codeword is a sign bit (1 means negative), a unary quotient of
// ones closed by a zero, and a truncated binary remainder for the divisor m
// held in the CSR (a written zero acts as one). One response is returned per
// completed codeword with the signed value and an overflow flag that is set
// when the magnitude saturated at 2^31-1. A request is registered on entry
// and is decoded from the input register once the response register can take
// a result, which is registered there; one request is taken every cycle
// as long as the response register is free or being drained. The divisor
// must only be written while no codeword is in flight in the block; the
// remainder width and threshold are derived at the time of the write.
module signed_golomb_decoder (
   input  logic                 clock,
   input  logic                 reset,
   sgd_req_if.sink              req_if,
   sgd_rsp_if.source            rsp_if,
   input  logic                 csr_we,
   input  sgd_pkg::divisor_type csr_wdata
);
   import sgd_pkg::*;

   // Divisor and the values derived from it.
   divisor_type divisor_ff;
   bits_type    width_ff;
   divisor_type threshold_ff;
   divisor_type divisor_eff;

   // Input register.
   logic in_valid_ff;
   logic in_bit_ff;

   // Decoder state.
   phase_type              phase_ff, phase_in;
   logic                   negative_ff, negative_in;
   logic [MAG_WIDTH-1:0]   mag_ff, mag_in;
   divisor_type            rem_ff, rem_in;
   bits_type               left_ff, left_in;
   logic                   sat_ff, sat_in;

   // Response register.
   logic      rsp_valid_ff;
   value_type rsp_value_ff;
   logic      rsp_overflow_ff;

   // Combinational step results.
   logic                   advance;
   logic                   finish;
   divisor_type            fin_rem;
   logic [MAG_WIDTH:0]     unary_sum;
   divisor_type            rem_shift;
   bits_type               left_dec;
   logic [DIVISOR_WIDTH:0] extra_v;
   logic [MAG_WIDTH:0]     mag_sum;
   logic [MAG_WIDTH-1:0]   mag_final;
   logic                   ovf_final;
   value_type              value_final;

   assign divisor_eff = (csr_wdata == '0) ? divisor_type'(1) : csr_wdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         divisor_ff   <= divisor_type'(1);
         width_ff     <= '0;
         threshold_ff <= '0;
      end else if (csr_we) begin
         divisor_ff   <= divisor_eff;
         width_ff     <= code_width(divisor_eff);
         threshold_ff <= code_threshold(divisor_eff, code_width(divisor_eff));
      end
   end

   // The registered bit moves on when the response register can take a result.
   assign advance       = in_valid_ff && (!rsp_valid_ff || rsp_if.ready);
   assign req_if.ready  = !in_valid_ff || advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_if.ready) begin
         in_valid_ff <= req_if.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_if.valid && req_if.ready) begin
         in_bit_ff <= req_if.code_bit;
      end
   end

   assign unary_sum = {1'b0, mag_ff} + (MAG_WIDTH + 1)'(divisor_ff);
   assign rem_shift = (rem_ff << 1) | divisor_type'(in_bit_ff);
   assign left_dec  = (left_ff != '0) ? left_ff - bits_type'(1) : left_ff;
   assign extra_v   = {rem_ff, in_bit_ff};

   // One step of the codeword parser.
   always_comb begin
      phase_in    = phase_ff;
      negative_in = negative_ff;
      mag_in      = mag_ff;
      rem_in      = rem_ff;
      left_in     = left_ff;
      sat_in      = sat_ff;
      finish      = 1'b0;
      fin_rem     = '0;
      unique case (phase_ff)
         PH_SIGN: begin
            negative_in = in_bit_ff;
            mag_in      = '0;
            rem_in      = '0;
            left_in     = '0;
            sat_in      = 1'b0;
            phase_in    = PH_UNARY;
         end
         PH_UNARY: begin
            if (in_bit_ff) begin
               // Add m per unary one and saturate at the largest magnitude.
               if (unary_sum[MAG_WIDTH]) begin
                  mag_in = MAG_MAX;
                  sat_in = 1'b1;
               end else begin
                  mag_in = unary_sum[MAG_WIDTH-1:0];
               end
            end else begin
               rem_in = '0;
               if (width_ff == '0) begin
                  finish = 1'b1;
               end else begin
                  left_in = width_ff - bits_type'(1);
                  if (left_in == '0) begin
                     // No short remainder bits: decide on a zero value.
                     if (threshold_ff != '0) begin
                        finish = 1'b1;
                     end else begin
                        phase_in = PH_EXTRA;
                     end
                  end else begin
                     phase_in = PH_REM;
                  end
               end
            end
         end
         PH_REM: begin
            rem_in  = rem_shift;
            left_in = left_dec;
            if (left_dec == '0) begin
               if (rem_shift < threshold_ff) begin
                  finish  = 1'b1;
                  fin_rem = rem_shift;
               end else begin
                  phase_in = PH_EXTRA;
               end
            end
         end
         PH_EXTRA: begin
            // A divisor change may leave the long value below t; clamp at zero.
            if (extra_v >= {1'b0, threshold_ff}) begin
               fin_rem = divisor_type'(extra_v - {1'b0, threshold_ff});
            end else begin
               fin_rem = '0;
            end
            rem_in = fin_rem;
            finish = 1'b1;
         end
         default: begin
            phase_in = PH_SIGN;
         end
      endcase
      if (finish) begin
         phase_in = PH_SIGN;
      end
   end

   // Assemble the signed result of a completed codeword.
   assign mag_sum     = {1'b0, mag_ff} + (MAG_WIDTH + 1)'(fin_rem);
   assign mag_final   = mag_sum[MAG_WIDTH] ? MAG_MAX : mag_sum[MAG_WIDTH-1:0];
   assign ovf_final   = sat_ff || mag_sum[MAG_WIDTH];
   assign value_final = negative_ff ? -value_type'({1'b0, mag_final})
                                    : value_type'({1'b0, mag_final});

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_SIGN;
         negative_ff <= 1'b0;
         mag_ff      <= '0;
         rem_ff      <= '0;
         left_ff     <= '0;
         sat_ff      <= 1'b0;
      end else if (advance) begin
         phase_ff    <= phase_in;
         negative_ff <= negative_in;
         mag_ff      <= mag_in;
         rem_ff      <= rem_in;
         left_ff     <= left_in;
         sat_ff      <= sat_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance && finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && finish) begin
         rsp_value_ff    <= value_final;
         rsp_overflow_ff <= ovf_final;
      end
   end

   assign rsp_if.valid         = rsp_valid_ff;
   assign rsp_if.decoded_value = rsp_value_ff;
   assign rsp_if.overflow      = rsp_overflow_ff;

endmodule

[test/tb.sv]
`timescale 1ns / 1ps

// Testbench for the sign-magnitude Golomb decoder. Code bits go in one request
// at a time. A bit-level decoder model in this file predicts the values that
// literal plan rows do not give; each response is checked against the oldest.
module tb;
   import sgd_pkg::*;

   localparam int unsigned     RANDOM_ITEMS = 1750;
   // A response passes the input register and then the response register, so
   // DRAIN_CYCLES quiet cycles are enough to be sure the block has nothing left.
   localparam int unsigned     DRAIN_CYCLES = 4;
   localparam int unsigned     STALL_LIMIT  = 5000;
   localparam longint unsigned MAG_LIMIT    = (64'd1 << (VALUE_WIDTH - 1)) - 64'd1;
   localparam int              PLAN_ROWS    = 29;
   localparam int              DIVISOR_KINDS = 17;

   typedef enum logic {
      ROW_BIT,
      ROW_CSR
   } row_kind_type;

   // One row of the directed stimulus. A CSR row writes data as the divisor.
   // A bit row sends data[0]; when literal is set, the row's value and overflow
   // are the expected response, otherwise the decoder model supplies it.
   typedef struct packed {
      row_kind_type             kind;
      logic [DIVISOR_WIDTH-1:0] data;
      logic                     literal;
      value_type                value;
      logic                     overflow;
   } plan_row_type;

   typedef struct packed {
      value_type value;
      logic      overflow;
   } decoded_type;

   logic clock;
   logic reset;
   logic csr_we;
   divisor_type csr_wdata;

   sgd_req_if req_ch ();
   sgd_rsp_if rsp_ch ();

   signed_golomb_decoder u_top (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_ch),
      .rsp_if    (rsp_ch),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   // Decoded values still to come out of the block, oldest first.
   decoded_type pending_values[$];

   int unsigned errors        = 0;
   int unsigned bits_sent     = 0;
   int unsigned send_idle_pct = 6;
   int unsigned recv_idle_pct = 79;

   // Decoder model state. It follows the block request by request, and the
   // divisor copy follows every CSR write.
   divisor_type     divisor_reg    = divisor_type'(1);
   phase_type       word_phase     = PH_SIGN;
   logic            word_negative  = 1'b0;
   longint unsigned quot_sum       = 0;
   longint unsigned rem_sum        = 0;
   int unsigned     rem_left       = 0;
   logic            word_saturated = 1'b0;

   // Directed part. Starting from the reset divisor of one: a plain zero, a
   // negative zero and a pure unary word. Then a written zero, which must act
   // as a divisor of one, a power of two where the remainder is a plain binary
   // number, a divisor of three where both the short and the long remainder
   // forms show up, and finally the largest divisor.
   plan_row_type plan [PLAN_ROWS] = '{
      '{ROW_BIT, 16'd0, 1'b0, 32'sd0, 1'b0},
      '{ROW_BIT, 16'd0, 1'b1, 32'sd0, 1'b0},
      '{ROW_BIT, 16'd1, 1'b0, 32'sd0, 1'b0},
      '{ROW_BIT, 16'd0, 1'b1, 32'sd0, 1'b0},
      '{ROW_BIT, 16'd1, 1'b0, 32'sd0, 1'b0},
      '{ROW_BIT, 16'd1, 1'b0, 32'sd0, 1'b0},
      '{ROW_BIT, 16'd1, 1'b0, 32'sd0, 1'b0},
      '{ROW_BIT, 16'd0, 1'b1, -32'sd2, 1'b0},
      '{ROW_CSR, 16'd0, 1'b0, 32'sd0, 1'b0},
      '{ROW_BIT, 16'd0, 1'b0, 32'sd0, 1'b0},
      '{ROW_BIT, 16'd1, 1'b0, 32'sd0, 1'b0},
      '{ROW_BIT, 16'd0, 1'b1, 32'sd1, 1'b0},
      '{ROW_CSR, 16'd8, 1'b0, 32'sd0, 1'b0},
      '{ROW_BIT, 16'd0, 1'b0, 32'sd0, 1'b0},
      '{ROW_BIT, 16'd1, 1'b0, 32'sd0, 1'b0},
      '{ROW_BIT, 16'd0, 1'b0, 32'sd0, 1'b0},
      '{ROW_BIT, 16'd1, 1'b0, 32'sd0, 1'b0},
      '{ROW_BIT, 16'd1, 1'b0, 32'sd0, 1'b0},
      '{ROW_BIT, 16'd1, 1'b0, 32'sd0, 1'b0},
      '{ROW_CSR, 16'd3, 1'b0, 32'sd0, 1'b0},
      '{ROW_BIT, 16'd0, 1'b0, 32'sd0, 1'b0},
      '{ROW_BIT, 16'd1, 1'b0, 32'sd0, 1'b0},
      '{ROW_BIT, 16'd0, 1'b0, 32'sd0, 1'b0},
      '{ROW_BIT, 16'd1, 1'b0, 32'sd0, 1'b0},
      '{ROW_BIT, 16'd1, 1'b0, 32'sd0, 1'b0},
      '{ROW_BIT, 16'd1, 1'b0, 32'sd0, 1'b0},
      '{ROW_BIT, 16'd0, 1'b0, 32'sd0, 1'b0},
      '{ROW_BIT, 16'd0, 1'b1, 32'sd0, 1'b0},
      '{ROW_CSR, 16'd65535, 1'b0, 32'sd0, 1'b0}
   };

   // Divisors that the random part walks through before it picks freely:
   // small ones, powers of two and their neighbors, both extremes and zero.
   divisor_type divisor_set [DIVISOR_KINDS] = '{
      16'd1, 16'd2, 16'd3, 16'd4, 16'd5, 16'd7, 16'd8, 16'd13, 16'd16, 16'd100,
      16'd255, 16'd256, 16'd1000, 16'd4097, 16'd32768, 16'd65535, 16'd0
   };

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // A zero in the register decodes as a divisor of one.
   function automatic longint unsigned effective_divisor();
      return (divisor_reg == '0) ? 64'd1 : 64'(divisor_reg);
   endfunction

   // Remainder width, the smallest b with 2^b >= m.
   function automatic int unsigned rem_width(input longint unsigned m);
      int unsigned w;
      w = 0;
      while (w < 40 && (64'd1 << w) < m) begin
         w++;
      end
      return w;
   endfunction

   function automatic void close_word(output value_type value, output logic ovf);
      longint unsigned total;
      total = quot_sum + rem_sum;
      ovf   = word_saturated;
      if (total > MAG_LIMIT) begin
         total = MAG_LIMIT;
         ovf   = 1'b1;
      end
      if (word_negative) begin
         total = ~total + 64'd1;
      end
      value      = value_type'(total[VALUE_WIDTH-1:0]);
      word_phase = PH_SIGN;
   endfunction

   // Advances the decoder model by one code bit. Returns 1 when the bit
   // completes a codeword, with the decoded value and overflow flag.
   function automatic logic predict_bit(input logic code, output value_type value,
                                        output logic ovf);
      longint unsigned m;
      longint unsigned t;
      longint unsigned x;
      int unsigned     w;
      m     = effective_divisor();
      w     = rem_width(m);
      t     = (64'd1 << w) - m;
      value = '0;
      ovf   = 1'b0;
      case (word_phase)
         PH_SIGN: begin
            word_negative  = code;
            quot_sum       = 0;
            rem_sum        = 0;
            rem_left       = 0;
            word_saturated = 1'b0;
            word_phase     = PH_UNARY;
            return 1'b0;
         end
         PH_UNARY: begin
            if (code) begin
               quot_sum += m;
               if (quot_sum > MAG_LIMIT) begin
                  quot_sum       = MAG_LIMIT;
                  word_saturated = 1'b1;
               end
               return 1'b0;
            end
            rem_sum = 0;
            if (w == 0) begin
               close_word(value, ovf);
               return 1'b1;
            end
            rem_left = w - 1;
            if (rem_left != 0) begin
               word_phase = PH_REM;
               return 1'b0;
            end
         end
         PH_REM: begin
            rem_sum = (rem_sum << 1) | 64'(code);
            if (rem_left > 0) begin
               rem_left--;
            end
            if (rem_left != 0) begin
               return 1'b0;
            end
         end
         default: begin
            x       = (rem_sum << 1) | 64'(code);
            rem_sum = (x >= t) ? x - t : 64'd0;
            close_word(value, ovf);
            return 1'b1;
         end
      endcase
      // The short part of the remainder is in. Below the threshold it is the
      // whole remainder; otherwise one more bit follows.
      if (rem_sum < t) begin
         close_word(value, ovf);
         return 1'b1;
      end
      word_phase = PH_EXTRA;
      return 1'b0;
   endfunction

   // Sends one code bit after a random idle gap and predicts its effect at
   // the edge where the request is taken. Valid stays high after a request
   // so that back-to-back requests need no second assignment in one step.
   task automatic send_bit(input logic code, input logic literal = 1'b0,
                           input value_type literal_value = '0,
                           input logic literal_ovf = 1'b0);
      int unsigned gap;
      value_type   value;
      logic        ovf;
      logic        done;
      gap = 0;
      while ($urandom_range(99) < send_idle_pct) begin
         gap++;
      end
      if (gap != 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid    <= 1'b1;
      req_ch.code_bit <= code;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      bits_sent++;
      done = predict_bit(code, value, ovf);
      if (literal) begin
         pending_values.push_back('{literal_value, literal_ovf});
      end else if (done) begin
         pending_values.push_back('{value, ovf});
      end
   endtask

   // Holds back requests until every predicted response is out, then lets the
   // pipeline settle.
   task automatic drain();
      req_ch.valid <= 1'b0;
      while (pending_values.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // The divisor is only written with the decoder between codewords and idle.
   task automatic write_divisor(input divisor_type divisor);
      drain();
      csr_we    <= 1'b1;
      csr_wdata <= divisor;
      @(posedge clock);
      divisor_reg = divisor;
      csr_we <= 1'b0;
   endtask

   // Encodes and sends one well-formed codeword for the current divisor: the
   // sign, quot ones and a closing zero, then the truncated binary remainder.
   task automatic put_word(input logic sign, input int unsigned quot,
                           input longint unsigned rem);
      longint unsigned m;
      longint unsigned t;
      longint unsigned code;
      int unsigned     w;
      int unsigned     n;
      m = effective_divisor();
      w = rem_width(m);
      t = (64'd1 << w) - m;
      send_bit(sign);
      repeat (quot) send_bit(1'b1);
      send_bit(1'b0);
      if (w != 0) begin
         if (rem < t) begin
            code = rem;
            n    = w - 1;
         end else begin
            code = rem + t;
            n    = w;
         end
         for (int i = int'(n) - 1; i >= 0; i--) begin
            send_bit(code[i]);
         end
      end
   endtask

   // Response side: random back-pressure and the comparison against the
   // oldest prediction. Values are sampled as they were before the edge.
   initial begin
      decoded_type want;
      rsp_ch.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
            if (pending_values.size() == 0) begin
               errors++;
               $display("%0t: unexpected response, value %0d overflow %0b",
                        $time, rsp_ch.decoded_value, rsp_ch.overflow);
            end else begin
               want = pending_values.pop_front();
               if (rsp_ch.decoded_value !== want.value) begin
                  errors++;
                  $display("%0t: decoded_value expected %0d actual %0d",
                           $time, want.value, rsp_ch.decoded_value);
               end
               if (rsp_ch.overflow !== want.overflow) begin
                  errors++;
                  $display("%0t: overflow expected %0b actual %0b",
                           $time, want.overflow, rsp_ch.overflow);
               end
            end
         end
         rsp_ch.ready <= !reset && ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // Watchdog: ends the run when neither channel moves for too long.
   initial begin
      int unsigned quiet;
      quiet = 0;
      forever begin
         @(posedge clock);
         if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
             (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
         if (quiet >= STALL_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
            $display("Test completed with failures");
            $finish;
         end
      end
   end

   initial begin
      int unsigned     random_start;
      int unsigned     seg;
      int unsigned     words;
      int unsigned     burst;
      int unsigned     quot_max;
      longint unsigned m;
      longint unsigned t;
      longint unsigned rem;
      divisor_type     divisor;

      req_ch.valid    <= 1'b0;
      req_ch.code_bit <= 1'b0;
      csr_we          <= 1'b0;
      csr_wdata       <= '0;
      reset           <= 1'b1;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CSR) begin
            write_divisor(plan[i].data);
         end else begin
            send_bit(plan[i].data[0], plan[i].literal, plan[i].value, plan[i].overflow);
         end
      end

      // Random part in three stretches: a slow receiver, then a slow sender,
      // then both at full rate. Each segment writes a divisor and sends a
      // handful of codewords with random content, now and then a burst of
      // raw bits, and now and then a pause until every response is back.
      random_start = bits_sent;
      seg          = 0;
      for (int mode = 0; mode < 3; mode++) begin
         send_idle_pct = (mode == 0) ? 6 : ((mode == 1) ? 79 : 0);
         recv_idle_pct = (mode == 0) ? 79 : ((mode == 1) ? 6 : 0);
         while (bits_sent - random_start < (mode + 1) * RANDOM_ITEMS / 3) begin
            if (seg >= DIVISOR_KINDS && $urandom_range(2) == 0) begin
               divisor = divisor_type'($urandom_range(65535));
            end else begin
               divisor = divisor_set[seg % DIVISOR_KINDS];
            end
            seg++;
            write_divisor(divisor);
            m        = effective_divisor();
            t        = (64'd1 << rem_width(m)) - m;
            quot_max = (m <= 4) ? 24 : ((m <= 64) ? 8 : 3);
            words    = $urandom_range(12, 4);
            repeat (words) begin
               if ($urandom_range(9) == 0) begin
                  // Raw bits, then zeros until the codeword they began is over.
                  burst = $urandom_range(20, 1);
                  repeat (burst) send_bit(1'($urandom_range(1)));
                  while (word_phase != PH_SIGN) begin
                     send_bit(1'b0);
                  end
               end else begin
                  case ($urandom_range(7))
                     0: rem = 0;
                     1: rem = m - 1;
                     2: rem = (t < m) ? t : 64'd0;
                     3: rem = (t > 0) ? t - 1 : m - 1;
                     default: rem = 64'($urandom_range(32'(m - 64'd1)));
                  endcase
                  put_word(1'($urandom_range(1)), $urandom_range(quot_max), rem);
               end
               if ($urandom_range(29) == 0) begin
                  drain();
               end
            end
         end
      end

      drain();
      if (errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
